// ===== sv/fsrl_pkg.sv =====
package fsrl_pkg;

  localparam int FMT_W      = 14;
  localparam int RATE_W     = 16;
  localparam int DUR_W      = 16;
  localparam int AMP_W      = 16;
  localparam int PROD_W     = RATE_W + DUR_W;
  localparam int NUM_LANES  = 4;

  localparam logic [FMT_W-1:0] FMT_MAX    = 14'h3FFF;
  localparam logic [AMP_W-1:0] AMP_THRESH = 16'd3276;
  localparam logic [DUR_W-1:0] DUR_FLOOR  = 16'd40;

  localparam int IN_TDATA_W  = 112;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LIMIT_ENABLE = 3'd0,
    CFG_APPLY_MASK   = 3'd1,
    CFG_RATE_CF2     = 3'd2,
    CFG_RATE_CF3     = 3'd3,
    CFG_RATE_PF2     = 3'd4,
    CFG_RATE_PF3     = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic load;    // first stage takes a new frame
    logic commit;  // a non-bypassed frame leaves the second stage and updates history
    logic limit;   // limiting applies to the frame in the second stage
  } lane_ctrl_t;

endpackage

// ===== sv/fsrl_lane.sv =====
module fsrl_lane (
  input  logic                              clk,
  input  logic                              rst,
  input  fsrl_pkg::lane_ctrl_t              ctrl,
  input  logic                              lane_en,
  input  logic [fsrl_pkg::RATE_W-1:0]       rate,
  input  logic [fsrl_pkg::DUR_W-1:0]        eff_dur,
  input  logic [fsrl_pkg::FMT_W-1:0]        f_in,
  output logic [fsrl_pkg::FMT_W-1:0]        f_out,
  output logic                              hit
);

  logic [fsrl_pkg::PROD_W-1:0] prod;
  logic [fsrl_pkg::FMT_W-1:0]  step;
  logic [fsrl_pkg::FMT_W-1:0]  f_s1;
  logic [fsrl_pkg::FMT_W-1:0]  prev;
  logic [fsrl_pkg::FMT_W-1:0]  d_up;
  logic [fsrl_pkg::FMT_W-1:0]  d_dn;

  assign prod = fsrl_pkg::PROD_W'(rate) * fsrl_pkg::PROD_W'(eff_dur);

  // The step is the Q8.8 product in whole Hz, saturated at the formant range.
  // Since the difference is an integer, diff * 256 > product exactly when
  // diff exceeds the truncated step, so the saturated step serves both uses.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      f_s1 <= f_in;
      if (|prod[fsrl_pkg::PROD_W-1:fsrl_pkg::FMT_W+8]) begin
        step <= fsrl_pkg::FMT_MAX;
      end else begin
        step <= prod[fsrl_pkg::FMT_W+7:8];
      end
    end
  end

  assign d_up = f_s1 - prev;
  assign d_dn = prev - f_s1;

  always_comb begin
    f_out = f_s1;
    hit   = 1'b0;
    if (ctrl.limit && lane_en) begin
      if (f_s1 > prev && d_up > step) begin
        f_out = prev + step;
        hit   = 1'b1;
      end else if (prev > f_s1 && d_dn > step) begin
        f_out = prev - step;
        hit   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev <= '0;
    end else if (ctrl.commit) begin
      prev <= f_out;
    end
  end

endmodule

// ===== sv/formant_slew_rate_limiter.sv =====
// Formant slew-rate limiter for a frame-based speech synthesizer.
// Input stream s_axis carries one frame per request: four formant frequencies,
// duration, class flags and source amplitudes in tdata, and the utterance
// start and bypass flags in tuser. Output stream m_axis returns one request
// per frame with the limited formants, the source change flag and a mask of
// clamped formants. Registers are written through the cfg channel, which is
// always ready; write them only while no frame is in flight.
// An accepted frame is registered in the first stage, then in the output
// register; a frame may be accepted in every cycle while the receiver is
// ready. The first stage forms rate * duration in four parallel lane
// multipliers; the second compares each lane against the last committed
// formant, merges the lane results and updates the history. When the receiver
// stalls, the output register holds its request and the first stage can still
// take one more frame; input ready drops only when both stages are full.
// Reset clears the registers, the frame history and both stage valids; the
// block is ready for input in the first cycle after reset.
module formant_slew_rate_limiter (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata, low bit up: cf2_in, cf3_in, pf2_in, pf3_in, duration_ms,
  // is_nasal, sharp_class, voice_amp, fric_amp, zero fill
  input  logic [fsrl_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // tuser, low bit up: utterance_start, bypass
  input  logic [fsrl_pkg::IN_TUSER_W-1:0]      s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // tdata, low bit up: cf2_out, cf3_out, pf2_out, pf3_out, source_change,
  // clamped_mask, zero fill
  output logic [fsrl_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [fsrl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fsrl_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int NL = fsrl_pkg::NUM_LANES;
  localparam int FW = fsrl_pkg::FMT_W;

  // Configuration registers
  logic                              limit_enable;
  logic [NL-1:0]                     apply_mask;
  logic [fsrl_pkg::RATE_W-1:0]       rate [NL];

  // First stage
  logic                              s1_valid;
  logic                              s1_start;
  logic                              s1_bypass;
  logic                              s1_dur_nz;
  logic                              s1_nasal;
  logic                              s1_sharp;
  logic                              s1_voiced;
  logic                              s1_fricated;

  // Frame history
  logic                              has_prev;
  logic                              prev_nasal;
  logic                              prev_voiced;
  logic                              prev_fricated;

  // Output register
  logic                              out_valid;
  logic [FW-1:0]                     out_f [NL];
  logic                              out_change;
  logic [NL-1:0]                     out_clamped;

  logic                              move;
  logic                              in_fire;
  logic                              s1_fire;
  logic [fsrl_pkg::DUR_W-1:0]        in_dur;
  logic [fsrl_pkg::DUR_W-1:0]        eff_dur;
  logic                              hp;
  logic                              limit;
  logic                              change;
  fsrl_pkg::lane_ctrl_t              lane_ctrl;
  logic [FW-1:0]                     lane_f [NL];
  logic [NL-1:0]                     lane_hit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_enable <= 1'b0;
      apply_mask   <= '0;
      for (int i = 0; i < NL; i++) begin
        rate[i] <= '0;
      end
    end else if (cfg_valid) begin
      unique case (fsrl_pkg::cfg_index_t'(cfg_index))
        fsrl_pkg::CFG_LIMIT_ENABLE: limit_enable <= cfg_data[0];
        fsrl_pkg::CFG_APPLY_MASK:   apply_mask   <= cfg_data[NL-1:0];
        fsrl_pkg::CFG_RATE_CF2:     rate[0]      <= cfg_data;
        fsrl_pkg::CFG_RATE_CF3:     rate[1]      <= cfg_data;
        fsrl_pkg::CFG_RATE_PF2:     rate[2]      <= cfg_data;
        fsrl_pkg::CFG_RATE_PF3:     rate[3]      <= cfg_data;
        default: ;
      endcase
    end
  end

  assign move          = !out_valid || m_axis_tready;
  assign s_axis_tready = !s1_valid || move;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign s1_fire       = s1_valid && move;

  assign in_dur  = s_axis_tdata[71:56];
  assign eff_dur = (in_dur > fsrl_pkg::DUR_FLOOR) ? in_dur : fsrl_pkg::DUR_FLOOR;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_start    <= s_axis_tuser[0];
      s1_bypass   <= s_axis_tuser[1];
      s1_dur_nz   <= |in_dur;
      s1_nasal    <= s_axis_tdata[72];
      s1_sharp    <= s_axis_tdata[73];
      s1_voiced   <= s_axis_tdata[89:74] > fsrl_pkg::AMP_THRESH;
      s1_fricated <= s_axis_tdata[105:90] > fsrl_pkg::AMP_THRESH;
    end
  end

  // An utterance start drops the history before the frame is judged.
  assign hp     = has_prev && !s1_start;
  assign limit  = limit_enable && hp && s1_dur_nz && !s1_sharp && !s1_nasal &&
                  !prev_nasal && !s1_bypass;
  assign change = !s1_bypass && hp &&
                  ((s1_voiced != prev_voiced) || (s1_fricated != prev_fricated));

  assign lane_ctrl.load   = in_fire;
  assign lane_ctrl.commit = s1_fire && !s1_bypass;
  assign lane_ctrl.limit  = limit;

  for (genvar g = 0; g < NL; g++) begin : g_lane
    fsrl_lane u_lane (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (lane_ctrl),
      .lane_en (apply_mask[g] && (rate[g] != '0)),
      .rate    (rate[g]),
      .eff_dur (eff_dur),
      .f_in    (s_axis_tdata[g*FW +: FW]),
      .f_out   (lane_f[g]),
      .hit     (lane_hit[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      has_prev      <= 1'b0;
      prev_nasal    <= 1'b0;
      prev_voiced   <= 1'b0;
      prev_fricated <= 1'b0;
    end else if (s1_fire) begin
      if (!s1_bypass) begin
        has_prev      <= 1'b1;
        prev_nasal    <= s1_nasal;
        prev_voiced   <= s1_voiced;
        prev_fricated <= s1_fricated;
      end else if (s1_start) begin
        has_prev <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      for (int i = 0; i < NL; i++) begin
        out_f[i] <= lane_f[i];
      end
      out_change  <= change;
      out_clamped <= lane_hit;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_clamped, out_change,
                          out_f[3], out_f[2], out_f[1], out_f[0]};

endmodule

// ===== sv/fsrl_checker.sv =====
module fsrl_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 s_axis_tvalid,
  input logic                                 s_axis_tready,
  input logic                                 m_axis_tvalid,
  input logic                                 m_axis_tready,
  input logic [fsrl_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  input logic                                 cfg_ready
);

  // A held output request keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output request changed while stalled");

  // Input backpressure only comes from a stalled, full output side.
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input not ready without an output stall");

  // Reset empties the pipeline and opens the input.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && s_axis_tready)
    else $error("pipeline not empty after reset");

  // A new output request comes from a frame accepted at the input and passed through the first stage.
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("output request without a prior input");

  // The register channel never pushes back.
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("register channel not ready");

endmodule

bind formant_slew_rate_limiter fsrl_checker u_fsrl_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .cfg_ready     (cfg_ready)
);

// ===== tb/sv/tb_formant_slew_rate_limiter.sv =====
`timescale 1ns / 100ps

module tb_formant_slew_rate_limiter;
  import fsrl_pkg::*;

  localparam int STALL_LIMIT = 4000;

  typedef struct {
    logic             start;
    logic             bypass;
    logic [FMT_W-1:0] fmt [NUM_LANES];
    logic [DUR_W-1:0] dur;
    logic             nasal;
    logic             sharp;
    logic [AMP_W-1:0] voice;
    logic [AMP_W-1:0] fric;
  } speech_frame_t;

  typedef struct {
    logic [FMT_W-1:0] fmt [NUM_LANES];
    logic             change;
    logic [3:0]       clamped;
  } limited_frame_t;

  // Tracks the limiter history and configuration and keeps the limited frames
  // that are still owed by the block, oldest first.
  class slew_scoreboard;
    bit                  enable;
    bit [3:0]            mask;
    bit [RATE_W-1:0]     rate [NUM_LANES];
    bit [FMT_W-1:0]      prev_fmt [NUM_LANES];
    bit [AMP_W-1:0]      prev_voice;
    bit [AMP_W-1:0]      prev_fric;
    bit                  has_prev;
    bit                  prev_nasal;
    limited_frame_t      owed_frames [$];
    int                  errors;
    string               lane_name [NUM_LANES] = '{"cf2_out", "cf3_out", "pf2_out", "pf3_out"};

    function void set_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_LIMIT_ENABLE: enable = value[0];
        CFG_APPLY_MASK:   mask = value[3:0];
        CFG_RATE_CF2:     rate[0] = value;
        CFG_RATE_CF3:     rate[1] = value;
        CFG_RATE_PF2:     rate[2] = value;
        CFG_RATE_PF3:     rate[3] = value;
        default: ;
      endcase
    endfunction

    function int pending();
      return owed_frames.size();
    endfunction

    function void note_frame(speech_frame_t f);
      limited_frame_t r;
      bit             limiting;
      bit [DUR_W-1:0] eff;
      bit [31:0]      span;
      bit [31:0]      step;
      bit [31:0]      diff;
      r.fmt = f.fmt;
      r.change = 1'b0;
      r.clamped = 4'b0;
      if (f.start) has_prev = 1'b0;
      if (!f.bypass) begin
        if (has_prev)
          r.change = ((f.voice > AMP_THRESH) != (prev_voice > AMP_THRESH)) ||
                     ((f.fric > AMP_THRESH) != (prev_fric > AMP_THRESH));
        limiting = enable && has_prev && f.dur != 0 && !f.sharp && !f.nasal && !prev_nasal;
        eff = (f.dur > DUR_FLOOR) ? f.dur : DUR_FLOOR;
        for (int i = 0; i < NUM_LANES; i++) begin
          if (limiting && mask[i] && rate[i] != 0) begin
            // The span is in Q8.8 Hz; the step applied is its whole-Hz part, capped at FMT_MAX.
            span = 32'(rate[i]) * 32'(eff);
            step = span >> 8;
            if (step > 32'(FMT_MAX)) step = 32'(FMT_MAX);
            if (f.fmt[i] > prev_fmt[i]) begin
              diff = 32'(f.fmt[i]) - 32'(prev_fmt[i]);
              if ((diff << 8) > span) begin
                r.fmt[i] = prev_fmt[i] + step[FMT_W-1:0];
                r.clamped[i] = 1'b1;
              end
            end else if (prev_fmt[i] > f.fmt[i]) begin
              diff = 32'(prev_fmt[i]) - 32'(f.fmt[i]);
              if ((diff << 8) > span) begin
                r.fmt[i] = prev_fmt[i] - step[FMT_W-1:0];
                r.clamped[i] = 1'b1;
              end
            end
          end
        end
        for (int i = 0; i < NUM_LANES; i++) prev_fmt[i] = r.fmt[i];
        prev_voice = f.voice;
        prev_fric = f.fric;
        has_prev = 1'b1;
        prev_nasal = f.nasal;
      end
      owed_frames.push_back(r);
    endfunction

    function void mismatch(string field, int want, int got);
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
    endfunction

    function void check_frame(logic [OUT_TDATA_W-1:0] t);
      limited_frame_t e;
      if (owed_frames.size() == 0) begin
        errors++;
        $display("%0t: result %h arrived with none expected", $time, t);
        return;
      end
      e = owed_frames.pop_front();
      for (int i = 0; i < NUM_LANES; i++)
        if (t[FMT_W*i +: FMT_W] !== e.fmt[i])
          mismatch(lane_name[i], int'(e.fmt[i]), int'(t[FMT_W*i +: FMT_W]));
      if (t[56] !== e.change) mismatch("source_change", int'(e.change), int'(t[56]));
      if (t[60:57] !== e.clamped) mismatch("clamped_mask", int'(e.clamped), int'(t[60:57]));
      if (t[63:61] !== 3'b0) mismatch("zero fill", 0, int'(t[63:61]));
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
  logic [IN_TUSER_W-1:0]   s_axis_tuser = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  m_axis_tdata;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;

  slew_scoreboard sb;
  int send_idle = 23;
  int recv_idle = 67;
  int quiet_cycles = 0;
  int walk [NUM_LANES] = '{8000, 8000, 8000, 8000};

  formant_slew_rate_limiter dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #1 clk = ~clk;

  // Receiver side: check every accepted result, then decide the next stall.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) sb.check_frame(m_axis_tdata);
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no request moved for %0d cycles", $time, STALL_LIMIT);
      $display("formant_slew_rate_limiter test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic speech_frame_t make_frame(
    logic start, logic bypass, int cf2, int cf3, int pf2, int pf3, int dur,
    logic nasal, logic sharp, int voice, int fric);
    speech_frame_t f;
    f.start = start;
    f.bypass = bypass;
    f.fmt[0] = FMT_W'(cf2);
    f.fmt[1] = FMT_W'(cf3);
    f.fmt[2] = FMT_W'(pf2);
    f.fmt[3] = FMT_W'(pf3);
    f.dur = DUR_W'(dur);
    f.nasal = nasal;
    f.sharp = sharp;
    f.voice = AMP_W'(voice);
    f.fric = AMP_W'(fric);
    return f;
  endfunction

  // Leaves valid high on return, so back-to-back frames need no extra edge.
  task automatic send_frame(input speech_frame_t f);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'b0, f.fric, f.voice, f.sharp, f.nasal, f.dur,
                     f.fmt[3], f.fmt[2], f.fmt[1], f.fmt[0]};
    s_axis_tuser <= {f.bypass, f.start};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_frame(f);
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, value);
  endtask

  task automatic write_config(input logic en, input logic [3:0] msk,
                              input logic [15:0] r_cf2, input logic [15:0] r_cf3,
                              input logic [15:0] r_pf2, input logic [15:0] r_pf3);
    put_reg(CFG_LIMIT_ENABLE, {15'b0, en});
    put_reg(CFG_APPLY_MASK, {12'b0, msk});
    put_reg(CFG_RATE_CF2, r_cf2);
    put_reg(CFG_RATE_CF3, r_cf3);
    put_reg(CFG_RATE_PF2, r_pf2);
    put_reg(CFG_RATE_PF3, r_pf3);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    speech_frame_t f;
    int            v;
    int            pick;
    sb = new;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Rates of 1 Hz/ms, the smallest step, the largest step and half a Hz/ms.
    write_config(1'b1, 4'hF, 16'h0100, 16'h0001, 16'hFFFF, 16'h0080);
    send_frame(make_frame(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_frame(make_frame(0, 0, 16383, 16383, 16383, 16383, 40, 0, 0, 65535, 65535));
    send_frame(make_frame(0, 0, 0, 0, 0, 0, 10, 0, 0, 0, 0));
    send_frame(make_frame(0, 0, 8000, 8000, 8000, 8000, 1000, 0, 0, 3276, 3277));
    send_frame(make_frame(0, 0, 16383, 0, 16383, 0, 65535, 0, 0, 3277, 3276));
    send_frame(make_frame(0, 0, 100, 200, 300, 400, 0, 0, 0, 3277, 3277));
    send_frame(make_frame(0, 0, 120, 200, 340, 419, 20, 0, 0, 3277, 3277));
    send_frame(make_frame(0, 1, 16383, 16383, 16383, 16383, 65535, 1, 1, 65535, 65535));
    send_frame(make_frame(0, 0, 10000, 10000, 10000, 10000, 50, 0, 0, 0, 0));
    send_frame(make_frame(0, 0, 0, 0, 0, 0, 60, 0, 1, 5000, 5000));
    send_frame(make_frame(0, 0, 16383, 16383, 16383, 16383, 60, 1, 0, 5000, 0));
    send_frame(make_frame(0, 0, 0, 0, 0, 0, 60, 0, 0, 0, 5000));
    send_frame(make_frame(0, 0, 'h2AAA, 'h1555, 'h2AAA, 'h1555, 'h5555, 0, 0, 'hAAAA, 'h5555));
    send_frame(make_frame(0, 0, 'h1555, 'h2AAA, 'h1555, 'h2AAA, 'hAAAA, 0, 0, 'h5555, 'hAAAA));
    send_frame(make_frame(0, 0, 3000, 3000, 3000, 3000, 80, 1, 0, 4000, 4000));
    // An utterance start on a bypassed frame still drops the history mark.
    send_frame(make_frame(1, 1, 1234, 2345, 3456, 4567, 80, 0, 0, 0, 0));
    send_frame(make_frame(0, 0, 16383, 16383, 16383, 16383, 40, 0, 0, 4000, 0));
    send_frame(make_frame(0, 0, 0, 0, 0, 0, 40, 0, 0, 0, 4000));
    send_frame(make_frame(1, 0, 16383, 16383, 16383, 16383, 40, 0, 0, 65535, 0));
    send_frame(make_frame(0, 0, 0, 0, 0, 0, 39, 0, 0, 0, 0));

    for (int phase = 1; phase <= 6; phase++) begin
      wait_for_results();
      if (phase == 3) begin
        send_idle = 67;
        recv_idle = 23;
      end else if (phase == 5) begin
        send_idle = 0;
        recv_idle = 0;
      end
      case (phase)
        1: write_config(1'b1, 4'hF, 16'($urandom_range(1, 'h200)),
                        16'($urandom_range(1, 'h200)), 16'($urandom_range(1, 'h200)),
                        16'($urandom_range(1, 'h200)));
        2: write_config(1'b1, 4'($urandom_range(15)), 16'($urandom), 16'($urandom),
                        16'($urandom), 16'($urandom));
        3: write_config(1'b0, 4'h0, 16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom));
        4: write_config(1'b1, 4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        5: write_config(1'b1, 4'hF, 16'h0001, 16'h0001, 16'h0001, 16'h0001);
        default: write_config(1'b1, 4'($urandom_range(15)), 16'h0000,
                              16'($urandom_range(1, 'h400)),
                              16'($urandom_range(1, 'h400)), 16'h0000);
      endcase
      for (int n = 0; n < 108; n++) begin
        if (n == 40 || $urandom_range(99) == 0) wait_for_results();
        // Mostly smooth trajectories with ordinary durations, so that the
        // limiter sees real history; the rest is arbitrary noise.
        f.start = ($urandom_range(39) == 0);
        f.bypass = ($urandom_range(9) == 0);
        f.nasal = ($urandom_range(9) == 0);
        f.sharp = ($urandom_range(11) == 0);
        for (int i = 0; i < NUM_LANES; i++) begin
          if ($urandom_range(9) < 7) begin
            v = walk[i] + int'($urandom_range(1200)) - 600;
            if (v < 0) v = 0;
            if (v > 16383) v = 16383;
          end else begin
            v = int'($urandom_range(16383));
          end
          walk[i] = v;
          f.fmt[i] = FMT_W'(v);
        end
        pick = int'($urandom_range(9));
        if (pick == 0) f.dur = '0;
        else if (pick == 1) f.dur = DUR_W'($urandom_range(65535));
        else if (pick < 4) f.dur = DUR_W'($urandom_range(1, 40));
        else f.dur = DUR_W'($urandom_range(41, 150));
        f.voice = ($urandom_range(3) == 0) ? AMP_W'($urandom_range(3268, 3284)) :
                                             AMP_W'($urandom_range(65535));
        f.fric = ($urandom_range(3) == 0) ? AMP_W'($urandom_range(3268, 3284)) :
                                            AMP_W'($urandom_range(65535));
        send_frame(f);
      end
    end

    wait_for_results();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("formant_slew_rate_limiter test passed");
    end else begin
      $display("formant_slew_rate_limiter test failed");
    end
    $finish;
  end

endmodule

// ===== formant_slew_rate_limiter.f =====
sv/fsrl_pkg.sv
sv/fsrl_lane.sv
sv/formant_slew_rate_limiter.sv
sv/fsrl_checker.sv
tb/sv/tb_formant_slew_rate_limiter.sv
